@@ hdl/spdq_pkg.sv @@
`timescale 1ns / 1ps
package spdq_pkg;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT      = 2'd0,
    FUNC_TAKE_URGENT = 2'd1,
    FUNC_TAKE_LAST   = 2'd2,
    FUNC_CLEAR       = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // the operation that every cell of the chain performs
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_DOWN
  } cell_op_t;

endpackage

@@ hdl/spdq_cell.sv @@
`timescale 1ns / 1ps
module spdq_cell #(
  parameter int TAG_BITS  = 32,
  parameter int PRIO_BITS = 8
) (
  input  logic                 clk,
  input  spdq_pkg::cell_op_t   op,
  input  logic                 occ,
  input  logic [TAG_BITS-1:0]  in_tag,
  input  logic [PRIO_BITS-1:0] in_prio,
  input  logic                 prev_behind,
  input  logic [TAG_BITS-1:0]  prev_tag,
  input  logic [PRIO_BITS-1:0] prev_prio,
  input  logic [TAG_BITS-1:0]  next_tag,
  input  logic [PRIO_BITS-1:0] next_prio,
  output logic                 behind,
  output logic [TAG_BITS-1:0]  tag,
  output logic [PRIO_BITS-1:0] prio
);
  import spdq_pkg::*;

  // new entry goes behind every held entry whose priority value is lower or equal
  assign behind = occ && (prio <= in_prio);

  always_ff @(posedge clk) begin
    case (op)
      CELL_INSERT: begin
        if (!behind) begin
          if (prev_behind) begin
            tag  <= in_tag;
            prio <= in_prio;
          end else begin
            tag  <= prev_tag;
            prio <= prev_prio;
          end
        end
      end
      CELL_SHIFT_DOWN: begin
        tag  <= next_tag;
        prio <= next_prio;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/sorted_priority_deque_unit.sv @@
`timescale 1ns / 1ps
// result: the result strobe (done) is registered and rises in the cycle after the accepting edge
// throughput: one transaction per cycle, every cell of the chain compares and
// shifts in parallel; busy stays low
// reset: rst (synchronous) empties the queue and drops any pending strobe;
// entry contents are not cleared. the receiver cannot stall
module sorted_priority_deque_unit #(
  parameter int DEPTH       = 16,
  parameter int TAG_BITS    = 32,
  parameter int PRIO_BITS   = 8,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [spdq_pkg::FUNC_W-1:0]    func,
  input  logic [TAG_BITS-1:0]            tag,
  input  logic [PRIO_BITS-1:0]           prio,
  output logic                           done,
  output logic [spdq_pkg::STATUS_W-1:0]  status,
  output logic                           is_empty,
  output logic [CNT_W-1:0]               entry_count,
  output logic [TAG_BITS-1:0]            head_tag,
  output logic [PRIO_BITS-1:0]           head_prio
);
  import spdq_pkg::*;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  status_t              status_r;
  status_t              status_next;
  cell_op_t             cell_op;
  logic                 accept;
  logic                 full;
  logic                 empty;
  func_t                fn;

  logic [DEPTH-1:0]     occ;
  logic [DEPTH-1:0]     behind;
  logic [TAG_BITS-1:0]  c_tag  [DEPTH];
  logic [PRIO_BITS-1:0] c_prio [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign fn     = func_t'(func);
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    cell_op     = CELL_HOLD;
    case (fn)
      FUNC_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cell_op    = CELL_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      FUNC_TAKE_URGENT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          cell_op    = CELL_SHIFT_DOWN;
          count_next = count - CNT_W'(1);
        end
      end
      FUNC_TAKE_LAST: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        count_next = '0;
      end
    endcase
    if (!accept) begin
      cell_op = CELL_HOLD;
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                 p_behind;
      logic [TAG_BITS-1:0]  p_tag;
      logic [PRIO_BITS-1:0] p_prio;
      logic [TAG_BITS-1:0]  n_tag;
      logic [PRIO_BITS-1:0] n_prio;

      assign occ[i] = (CNT_W'(i) < count);

      if (i == 0) begin : g_first
        assign p_behind = 1'b1;
        assign p_tag    = c_tag[0];
        assign p_prio   = c_prio[0];
      end else begin : g_mid
        assign p_behind = behind[i-1];
        assign p_tag    = c_tag[i-1];
        assign p_prio   = c_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
        assign n_tag  = c_tag[i];
        assign n_prio = c_prio[i];
      end else begin : g_inner
        assign n_tag  = c_tag[i+1];
        assign n_prio = c_prio[i+1];
      end

      spdq_cell #(
        .TAG_BITS  (TAG_BITS),
        .PRIO_BITS (PRIO_BITS)
      ) u_cell (
        .clk         (clk),
        .op          (cell_op),
        .occ         (occ[i]),
        .in_tag      (tag),
        .in_prio     (prio),
        .prev_behind (p_behind),
        .prev_tag    (p_tag),
        .prev_prio   (p_prio),
        .next_tag    (n_tag),
        .next_prio   (n_prio),
        .behind      (behind[i]),
        .tag         (c_tag[i]),
        .prio        (c_prio[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      done     <= 1'b0;
      status_r <= ST_DONE;
    end else begin
      done <= accept;
      if (accept) begin
        count    <= count_next;
        status_r <= status_next;
      end
    end
  end

  assign status      = status_r;
  assign is_empty    = empty;
  assign entry_count = count;
  assign head_tag    = empty ? '0 : c_tag[0];
  assign head_prio   = empty ? '0 : c_prio[0];

endmodule

@@ hdl/spdq_checker.sv @@
`timescale 1ns / 1ps
module spdq_checker #(
  parameter int DEPTH       = 16,
  parameter int TAG_BITS    = 32,
  parameter int PRIO_BITS   = 8,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [spdq_pkg::FUNC_W-1:0]   func,
  input logic                          done,
  input logic [spdq_pkg::STATUS_W-1:0] status,
  input logic                          is_empty,
  input logic [CNT_W-1:0]              entry_count,
  input logic [TAG_BITS-1:0]           head_tag,
  input logic [PRIO_BITS-1:0]          head_prio
);
  import spdq_pkg::*;

  // every accepted transaction gives exactly one strobe on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("missing result strobe");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result strobe without transaction");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (done && is_empty) |-> (entry_count == '0 && head_tag == '0 && head_prio == '0))
    else $error("empty queue reports a head entry");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count <= CNT_W'(DEPTH) && is_empty == (entry_count == '0)))
    else $error("entry count out of range");

  // a clear always succeeds and leaves nothing behind
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && func == FUNC_CLEAR) |=>
      (status == ST_DONE && is_empty))
    else $error("clear did not empty the queue");

endmodule

bind sorted_priority_deque_unit spdq_checker #(
  .DEPTH     (DEPTH),
  .TAG_BITS  (TAG_BITS),
  .PRIO_BITS (PRIO_BITS)
) u_spdq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .func        (func),
  .done        (done),
  .status      (status),
  .is_empty    (is_empty),
  .entry_count (entry_count),
  .head_tag    (head_tag),
  .head_prio   (head_prio)
);

@@ sim/tb_sorted_priority_deque_unit.sv @@
`timescale 1ns / 1ps
module tb_sorted_priority_deque_unit;
  import spdq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int TAG_BITS   = 32;
  localparam int PRIO_BITS  = 8;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int RANDOM_OPS = 700;
  localparam int STALL_MAX  = 2000;

  typedef struct {
    func_t                op;
    logic [TAG_BITS-1:0]  tag;
    logic [PRIO_BITS-1:0] prio;
  } queue_cmd_t;

  typedef struct {
    status_t              status;
    logic                 is_empty;
    logic [CNT_W-1:0]     count;
    logic [TAG_BITS-1:0]  head_tag;
    logic [PRIO_BITS-1:0] head_prio;
    longint unsigned      stamp;
  } queue_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  func_t                 func = FUNC_INSERT;
  logic [TAG_BITS-1:0]   tag = '0;
  logic [PRIO_BITS-1:0]  prio = '0;
  logic                  busy;
  logic                  done;
  logic [STATUS_W-1:0]   status;
  logic                  is_empty;
  logic [CNT_W-1:0]      entry_count;
  logic [TAG_BITS-1:0]   head_tag;
  logic [PRIO_BITS-1:0]  head_prio;

  queue_cmd_t    pending_cmds[$];
  queue_report_t expected_reports[$];
  int            total_cmds;
  int            accepted_cmds = 0;
  int            errors = 0;
  int            quiet_cycles = 0;
  int            shadow_fill = 0;

  // predictor state: sorted entries, slot 0 most urgent
  logic [TAG_BITS-1:0]  model_tag[DEPTH];
  logic [PRIO_BITS-1:0] model_prio[DEPTH];
  int                   model_held = 0;

  always #5 clk = ~clk;

  sorted_priority_deque_unit #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS),
    .PRIO_BITS(PRIO_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .tag        (tag),
    .prio       (prio),
    .done       (done),
    .status     (status),
    .is_empty   (is_empty),
    .entry_count(entry_count),
    .head_tag   (head_tag),
    .head_prio  (head_prio)
  );

  function automatic queue_report_t apply_queue_op(func_t op, logic [TAG_BITS-1:0] t,
                                                   logic [PRIO_BITS-1:0] p);
    queue_report_t r;
    int pos;
    r.status = ST_DONE;
    case (op)
      FUNC_INSERT: begin
        if (model_held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // equal priorities go behind the older entries
          pos = 0;
          while (pos < model_held && model_prio[pos] <= p) pos++;
          for (int i = model_held; i > pos; i--) begin
            model_tag[i]  = model_tag[i-1];
            model_prio[i] = model_prio[i-1];
          end
          model_tag[pos]  = t;
          model_prio[pos] = p;
          model_held++;
        end
      end
      FUNC_TAKE_URGENT: begin
        if (model_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 1; i < model_held; i++) begin
            model_tag[i-1]  = model_tag[i];
            model_prio[i-1] = model_prio[i];
          end
          model_held--;
        end
      end
      FUNC_TAKE_LAST: begin
        if (model_held == 0) r.status = ST_EMPTY;
        else model_held--;
      end
      default: model_held = 0;
    endcase
    r.is_empty  = (model_held == 0);
    r.count     = CNT_W'(model_held);
    r.head_tag  = (model_held == 0) ? '0 : model_tag[0];
    r.head_prio = (model_held == 0) ? '0 : model_prio[0];
    r.stamp     = 0;
    return r;
  endfunction

  task automatic add_cmd(func_t op, logic [TAG_BITS-1:0] t, logic [PRIO_BITS-1:0] p);
    queue_cmd_t c;
    c.op   = op;
    c.tag  = t;
    c.prio = p;
    pending_cmds.insert(pending_cmds.size(), c);
    case (op)
      FUNC_INSERT:  if (shadow_fill < DEPTH) shadow_fill++;
      FUNC_CLEAR:   shadow_fill = 0;
      default:      if (shadow_fill > 0) shadow_fill--;
    endcase
  endtask

  function automatic logic [PRIO_BITS-1:0] pick_prio();
    int r;
    r = $urandom_range(99);
    if (r < 50) return PRIO_BITS'($urandom_range(7));
    if (r < 90) return PRIO_BITS'($urandom_range(255));
    return $urandom_range(1) ? {PRIO_BITS{1'b1}} : {PRIO_BITS{1'b0}};
  endfunction

  // driver: one transaction offered at a time, held until accepted
  always @(posedge clk) begin
    queue_cmd_t    c;
    queue_report_t r;
    int            idle_pct;
    logic          offer;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        r       = apply_queue_op(func, tag, prio);
        r.stamp = $time;
        expected_reports.insert(expected_reports.size(), r);
        accepted_cmds++;
      end
      if (accepted_cmds < total_cmds / 3) idle_pct = 6;
      else if (accepted_cmds < 2 * total_cmds / 3) idle_pct = 70;
      else idle_pct = 0;
      offer = 1'b0;
      if (start && busy) begin
        offer = 1'b1;
      end else if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        c = pending_cmds[0];
        pending_cmds.delete(0);
        func  <= c.op;
        tag   <= c.tag;
        prio  <= c.prio;
        offer = 1'b1;
      end
      start <= offer;
    end
  end

  // monitor: results are never held off, so every strobe is a transaction
  always @(posedge clk) begin
    queue_report_t e;
    if (!rst && done) begin
      if (expected_reports.size() == 0 || expected_reports[0].stamp >= $time) begin
        $error("result strobe with no transaction outstanding");
        errors++;
      end else begin
        e = expected_reports[0];
        expected_reports.delete(0);
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          errors++;
        end
        if (is_empty !== e.is_empty) begin
          $error("is_empty: expected %0d, got %0d", e.is_empty, is_empty);
          errors++;
        end
        if (entry_count !== e.count) begin
          $error("entry_count: expected %0d, got %0d", e.count, entry_count);
          errors++;
        end
        if (head_tag !== e.head_tag) begin
          $error("head_tag: expected %h, got %h", e.head_tag, head_tag);
          errors++;
        end
        if (head_prio !== e.head_prio) begin
          $error("head_prio: expected %0d, got %0d", e.head_prio, head_prio);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic filling;
    int   r;
    // removals and clear on an empty queue
    add_cmd(FUNC_CLEAR, $urandom, PRIO_BITS'($urandom_range(255)));
    add_cmd(FUNC_TAKE_URGENT, $urandom, PRIO_BITS'($urandom_range(255)));
    add_cmd(FUNC_TAKE_LAST, $urandom, PRIO_BITS'($urandom_range(255)));
    // extreme fields and a tie on the most urgent priority
    add_cmd(FUNC_INSERT, '1, '1);
    add_cmd(FUNC_INSERT, '0, '0);
    add_cmd(FUNC_INSERT, 32'h0000_0001, '0);
    add_cmd(FUNC_TAKE_URGENT, '0, '0);
    add_cmd(FUNC_TAKE_LAST, '1, '1);
    // fill to the brim with repeated priorities, then overflow
    for (int i = 0; i < DEPTH - 1; i++)
      add_cmd(FUNC_INSERT, 32'hA5A5_0000 + i, PRIO_BITS'((i % 5) * 60));
    add_cmd(FUNC_INSERT, 32'h5A5A_5A5A, 8'd1);
    add_cmd(FUNC_CLEAR, '0, '0);

    // random walk of fill and drain runs so that full and empty both recur
    filling = 1'b1;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (shadow_fill == DEPTH && $urandom_range(99) < 30) filling = 1'b0;
      if (shadow_fill == 0) filling = 1'b1;
      r = $urandom_range(99);
      if (r < 3)
        add_cmd(FUNC_CLEAR, $urandom, PRIO_BITS'($urandom_range(255)));
      else if ((filling && r < 75) || (!filling && r >= 75))
        add_cmd(FUNC_INSERT, $urandom, pick_prio());
      else
        add_cmd($urandom_range(1) ? FUNC_TAKE_URGENT : FUNC_TAKE_LAST, $urandom,
                PRIO_BITS'($urandom_range(255)));
    end
    total_cmds = pending_cmds.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (pending_cmds.size() == 0 && !start && expected_reports.size() == 0);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
